// File: hw/rtl/cbc_pkg.sv
package cbc_pkg;

  localparam int unsigned CoordW = 16;
  localparam int unsigned SizeW = 15;
  localparam int unsigned OffW = 19;
  localparam int unsigned LenW = 32;
  localparam int unsigned NormBits = 15;
  localparam int unsigned AccW = 67;
  localparam int unsigned QueueDepth = 2;

  typedef struct packed {
    logic hit;
    logic active;
    logic signed [OffW-1:0] dx;
    logic signed [OffW-1:0] dy;
    logic [SizeW-1:0] r;
    logic [LenW-1:0] len2;
  } work_t;

  typedef struct packed {
    logic [NormBits-1:0] mag;
    logic signed [AccW-1:0] p;
    logic signed [AccW-1:0] el;
    logic signed [AccW-1:0] lim;
  } lane_t;

  // one trial bit of the rounded unit magnitude, squares kept by shifts and adds
  function automatic lane_t norm_step(lane_t cur, logic [LenW-1:0] len2, int unsigned b);
    lane_t nxt;
    logic signed [AccW-1:0] l_ext;
    logic signed [AccW-1:0] p_try;
    logic signed [AccW-1:0] e_try;
    l_ext = signed'({{(AccW-LenW){1'b0}}, len2});
    p_try = cur.p + (cur.el <<< (b + 2)) + (l_ext <<< (2 * b + 2));
    e_try = cur.el + (l_ext <<< (b + 1));
    nxt = cur;
    if (p_try <= cur.lim) begin
      nxt.mag = cur.mag | (NormBits'(1) << b);
      nxt.p = p_try;
      nxt.el = e_try;
    end
    return nxt;
  endfunction

endpackage

// File: hw/rtl/cbc_req_if.sv
interface cbc_req_if;
  logic valid;
  logic ready;
  logic signed [cbc_pkg::CoordW-1:0] circle_x;
  logic signed [cbc_pkg::CoordW-1:0] circle_y;
  logic [cbc_pkg::SizeW-1:0] circle_radius;
  logic signed [cbc_pkg::CoordW-1:0] box_x;
  logic signed [cbc_pkg::CoordW-1:0] box_y;
  logic [cbc_pkg::SizeW-1:0] box_width;
  logic [cbc_pkg::SizeW-1:0] box_height;

  modport source(output valid, circle_x, circle_y, circle_radius, box_x, box_y, box_width,
                 box_height, input ready);
  modport sink(input valid, circle_x, circle_y, circle_radius, box_x, box_y, box_width,
               box_height, output ready);
endinterface

// File: hw/rtl/cbc_rsp_if.sv
interface cbc_rsp_if;
  logic valid;
  logic ready;
  logic hit;
  logic signed [15:0] normal_x;
  logic signed [15:0] normal_y;
  logic signed [15:0] depth_x;
  logic signed [15:0] depth_y;

  modport source(output valid, hit, normal_x, normal_y, depth_x, depth_y, input ready);
  modport sink(input valid, hit, normal_x, normal_y, depth_x, depth_y, output ready);
endinterface

// File: hw/rtl/cbc_front.sv
module cbc_front (
  input  logic            clk,
  input  logic            rst,
  cbc_req_if.sink         req,
  output logic            item_valid,
  input  logic            item_ready,
  output cbc_pkg::work_t  item
);

  localparam int unsigned OffW = cbc_pkg::OffW;
  localparam int unsigned SizeW = cbc_pkg::SizeW;

  logic en;
  logic v1, v2;
  logic signed [OffW-1:0] dx1, dy1;
  logic [SizeW-1:0] r1, r2;
  logic signed [OffW-1:0] dx2, dy2;
  logic [35:0] sqx, sqy;
  logic [2*SizeW-1:0] rr;
  logic signed [OffW-1:0] dx_c, dy_c;
  logic signed [2*OffW-1:0] px, py;
  logic [36:0] len_full;
  logic hit_c;

  function automatic logic signed [OffW-1:0] offset(logic signed [15:0] c,
                                                     logic signed [15:0] b,
                                                     logic [SizeW-1:0] w);
    logic signed [OffW-1:0] c2, lo, hi, cl;
    c2 = signed'({{2{c[15]}}, c, 1'b0});
    lo = signed'({{2{b[15]}}, b, 1'b0}) - signed'({4'b0, w});
    hi = signed'({{2{b[15]}}, b, 1'b0}) + signed'({4'b0, w});
    if (c2 < lo) begin
      cl = lo;
    end else if (c2 > hi) begin
      cl = hi;
    end else begin
      cl = c2;
    end
    return cl - c2;
  endfunction

  assign en = !item_valid || item_ready;
  assign req.ready = en;

  assign dx_c = offset(req.circle_x, req.box_x, req.box_width);
  assign dy_c = offset(req.circle_y, req.box_y, req.box_height);
  assign px = dx1 * dx1;
  assign py = dy1 * dy1;
  assign len_full = {1'b0, sqx} + {1'b0, sqy};
  assign hit_c = len_full < {5'b0, rr, 2'b00};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      item_valid <= 1'b0;
    end else if (en) begin
      v1 <= req.valid;
      v2 <= v1;
      item_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx1 <= dx_c;
      dy1 <= dy_c;
      r1 <= req.circle_radius;
      dx2 <= dx1;
      dy2 <= dy1;
      r2 <= r1;
      sqx <= px[35:0];
      sqy <= py[35:0];
      rr <= r1 * r1;
      item.hit <= hit_c;
      item.active <= hit_c && (len_full != '0);
      item.dx <= dx2;
      item.dy <= dy2;
      item.r <= r2;
      item.len2 <= len_full[cbc_pkg::LenW-1:0];
    end
  end

endmodule

// File: hw/rtl/cbc_queue.sv
module cbc_queue #(
  parameter int unsigned Depth = cbc_pkg::QueueDepth
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  output logic            push_ready,
  input  cbc_pkg::work_t  push_item,
  output logic            pop_valid,
  input  logic            pop_ready,
  output cbc_pkg::work_t  pop_item
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cbc_pkg::work_t mem [0:Depth-1];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] count;
  logic push, pop;

  assign push_ready = count != CntW'(Depth);
  assign pop_valid = count != '0;
  assign push = push_valid && push_ready;
  assign pop = pop_valid && pop_ready;
  assign pop_item = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

endmodule

// File: hw/rtl/cbc_back.sv
module cbc_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  output logic            item_ready,
  input  cbc_pkg::work_t  item,
  cbc_rsp_if.source       rsp
);

  localparam int unsigned Steps = cbc_pkg::NormBits;
  localparam int unsigned AccW = cbc_pkg::AccW;
  localparam int unsigned OffW = cbc_pkg::OffW;

  logic en;
  logic [Steps+1:0] vld;
  cbc_pkg::work_t meta [0:Steps+1];
  cbc_pkg::lane_t lx [0:Steps];
  cbc_pkg::lane_t ly [0:Steps];
  logic signed [15:0] nx, ny;
  logic signed [31:0] prod_x, prod_y;
  logic signed [15:0] nx_c, ny_c;

  function automatic logic [15:0] abs16(logic signed [OffW-1:0] d);
    logic [OffW-1:0] a;
    a = d[OffW-1] ? unsigned'(-d) : unsigned'(d);
    return a[15:0];
  endfunction

  function automatic cbc_pkg::lane_t lane_init(logic signed [OffW-1:0] d,
                                               logic [cbc_pkg::LenW-1:0] len2);
    cbc_pkg::lane_t l;
    logic [15:0] a;
    logic [31:0] sq;
    a = abs16(d);
    sq = 32'(a) * 32'(a);
    l.mag = '0;
    l.p = signed'(AccW'(len2));
    l.el = -signed'(AccW'(len2));
    l.lim = signed'(AccW'(sq) << 30);
    return l;
  endfunction

  function automatic logic signed [15:0] sign_norm(logic signed [OffW-1:0] d,
                                                   logic [Steps-1:0] mag);
    logic signed [15:0] m;
    m = signed'({1'b0, mag});
    return (d > 0) ? -m : m;
  endfunction

  function automatic logic signed [15:0] depth(logic signed [31:0] prod,
                                               logic signed [OffW-1:0] d);
    logic signed [33:0] v;
    logic [33:0] av;
    logic [19:0] m;
    logic signed [15:0] res;
    v = -34'(prod) - (34'(d) <<< 13);
    av = v[33] ? unsigned'(-v) : unsigned'(v);
    m = 20'((av + 34'd8192) >> 14);
    if (!v[33]) begin
      res = (m > 20'd32767) ? 16'sd32767 : signed'(m[15:0]);
    end else begin
      res = (m > 20'd32768) ? -16'sd32768 : -signed'(m[15:0]);
    end
    return res;
  endfunction

  assign en = !rsp.valid || rsp.ready;
  assign item_ready = en;
  assign nx_c = sign_norm(meta[Steps].dx, lx[Steps].mag);
  assign ny_c = sign_norm(meta[Steps].dy, ly[Steps].mag);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      rsp.valid <= 1'b0;
    end else if (en) begin
      vld <= {vld[Steps:0], item_valid};
      rsp.valid <= vld[Steps+1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      meta[0] <= item;
      lx[0] <= lane_init(item.dx, item.len2);
      ly[0] <= lane_init(item.dy, item.len2);
    end
  end

  for (genvar k = 0; k < Steps; k++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        meta[k+1] <= meta[k];
        lx[k+1] <= cbc_pkg::norm_step(lx[k], meta[k].len2, Steps - 1 - k);
        ly[k+1] <= cbc_pkg::norm_step(ly[k], meta[k].len2, Steps - 1 - k);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      meta[Steps+1] <= meta[Steps];
      nx <= nx_c;
      ny <= ny_c;
      prod_x <= nx_c * signed'({1'b0, meta[Steps].r});
      prod_y <= ny_c * signed'({1'b0, meta[Steps].r});
      rsp.hit <= meta[Steps+1].hit;
      rsp.normal_x <= meta[Steps+1].active ? nx : '0;
      rsp.normal_y <= meta[Steps+1].active ? ny : '0;
      rsp.depth_x <= meta[Steps+1].active ? depth(prod_x, meta[Steps+1].dx) : '0;
      rsp.depth_y <= meta[Steps+1].active ? depth(prod_y, meta[Steps+1].dy) : '0;
    end
  end

endmodule

// File: hw/rtl/circle_box_collision_unit.sv
// Circle versus axis-aligned box contact test. Takes one transfer per cycle and
// returns one result transfer for each, in order, while the response side is not
// stalled. The path has 3 front stages (offset, squares, hit test), the queue,
// and 18 back stages, of which 15 are the bit-serial normalizer that resolves
// one bit of the Q1.14 normal per stage for both axes.
module circle_box_collision_unit #(
  parameter int unsigned QueueDepth = cbc_pkg::QueueDepth
) (
  input  logic  clk,
  input  logic  rst,
  cbc_req_if.sink    req,
  cbc_rsp_if.source  rsp
);

  logic f_valid, f_ready, b_valid, b_ready;
  cbc_pkg::work_t f_item, b_item;

  cbc_front u_front (
    .clk(clk), .rst(rst), .req(req),
    .item_valid(f_valid), .item_ready(f_ready), .item(f_item)
  );

  cbc_queue #(.Depth(QueueDepth)) u_queue (
    .clk(clk), .rst(rst),
    .push_valid(f_valid), .push_ready(f_ready), .push_item(f_item),
    .pop_valid(b_valid), .pop_ready(b_ready), .pop_item(b_item)
  );

  cbc_back u_back (
    .clk(clk), .rst(rst),
    .item_valid(b_valid), .item_ready(b_ready), .item(b_item), .rsp(rsp)
  );

endmodule

// File: tb/circle_box_collision_unit_tb.sv
module circle_box_collision_unit_tb;

  typedef struct {
    logic hit;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] depth_x;
    logic signed [15:0] depth_y;
  } contact_t;

  logic clk;
  logic rst;
  cbc_req_if req ();
  cbc_rsp_if rsp ();

  circle_box_collision_unit dut (
    .clk(clk),
    .rst(rst),
    .req(req.sink),
    .rsp(rsp.source)
  );

  contact_t expected_contacts[$];
  int errors = 0;
  int idle_cycles = 0;
  int hits_seen = 0;
  int contacts_seen = 0;
  bit rsp_stall_on = 1;

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  function automatic longint clamp_l(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic bit mag_fits(longint t, longint a, longint len2);
    longint e;
    e = 2 * t - 1;
    return e * e * len2 <= ((a * a) <<< 30);
  endfunction

  function automatic longint unit_magnitude(longint a, longint len2);
    longint q;
    longint t;
    q = 0;
    if (len2 == 0 || a == 0) return 0;
    if (mag_fits(16384, a, len2)) return 16384;
    for (int b = 13; b >= 0; b--) begin
      t = q | (longint'(1) << b);
      if (mag_fits(t, a, len2)) q = t;
    end
    return q;
  endfunction

  function automatic longint round_q14(longint n);
    if (n >= 0) return (n + 8192) >>> 14;
    return -((-n + 8192) >>> 14);
  endfunction

  function automatic void axis_contact(longint d, longint len2, longint r,
                                       output logic signed [15:0] nrm,
                                       output logic signed [15:0] dep);
    longint m;
    longint n;
    m = unit_magnitude(d < 0 ? -d : d, len2);
    n = (d > 0) ? -m : m;
    nrm = 16'(n);
    dep = 16'(clamp_l(round_q14(-n * r - d * 8192), -32768, 32767));
  endfunction

  function automatic contact_t predict_contact(logic signed [15:0] cx, logic signed [15:0] cy,
                                               logic [14:0] r, logic signed [15:0] bx,
                                               logic signed [15:0] by, logic [14:0] w,
                                               logic [14:0] h);
    contact_t c;
    longint dx;
    longint dy;
    longint len2;
    longint rl;
    rl = r;
    dx = clamp_l(2 * longint'(cx), 2 * longint'(bx) - w, 2 * longint'(bx) + w) - 2 * longint'(cx);
    dy = clamp_l(2 * longint'(cy), 2 * longint'(by) - h, 2 * longint'(by) + h) - 2 * longint'(cy);
    len2 = dx * dx + dy * dy;
    c.hit = len2 < 4 * rl * rl;
    c.normal_x = 0;
    c.normal_y = 0;
    c.depth_x = 0;
    c.depth_y = 0;
    if (c.hit && len2 != 0) begin
      axis_contact(dx, len2, rl, c.normal_x, c.depth_x);
      axis_contact(dy, len2, rl, c.normal_y, c.depth_y);
    end
    return c;
  endfunction

  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(5, 30);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  task automatic send_pair(logic signed [15:0] cx, logic signed [15:0] cy, logic [14:0] r,
                           logic signed [15:0] bx, logic signed [15:0] by, logic [14:0] w,
                           logic [14:0] h, bit gaps = 1);
    int g;
    g = gaps ? gap_len() : 0;
    @(negedge clk);
    if (g > 0) begin
      req.valid <= 0;
      repeat (g) @(negedge clk);
    end
    req.valid <= 1;
    req.circle_x <= cx;
    req.circle_y <= cy;
    req.circle_radius <= r;
    req.box_x <= bx;
    req.box_y <= by;
    req.box_width <= w;
    req.box_height <= h;
    expected_contacts = {expected_contacts, predict_contact(cx, cy, r, bx, by, w, h)};
    do @(posedge clk); while (!req.ready);
  endtask

  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready) begin
      contact_t e;
      contacts_seen++;
      if (expected_contacts.size() == 0) begin
        $display("%0t: unexpected result hit=%0d", $time, rsp.hit);
        errors++;
      end else begin
        e = expected_contacts.pop_front();
        if (rsp.hit) hits_seen++;
        if (rsp.hit !== e.hit || rsp.normal_x !== e.normal_x || rsp.normal_y !== e.normal_y
            || rsp.depth_x !== e.depth_x || rsp.depth_y !== e.depth_y) begin
          $display("%0t: expected %0d n=(%0d,%0d) d=(%0d,%0d) actual %0d n=(%0d,%0d) d=(%0d,%0d)",
                   $time, e.hit, e.normal_x, e.normal_y, e.depth_x, e.depth_y, rsp.hit,
                   rsp.normal_x, rsp.normal_y, rsp.depth_x, rsp.depth_y);
          errors++;
        end
      end
    end
  end

  initial begin
    int g;
    rsp.ready = 0;
    forever begin
      @(negedge clk);
      if (!rsp_stall_on) rsp.ready <= 1;
      else begin
        g = gap_len();
        if (g == 0) rsp.ready <= 1;
        else begin
          rsp.ready <= 0;
          repeat (g - 1) @(negedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 4000) begin
      $display("circle_box_collision_unit regression: fail");
      $finish;
    end
  end

  task automatic test_extremes();
    send_pair(0, 0, 16, 0, 0, 64, 64);
    send_pair(0, 0, 0, 0, 0, 64, 64);
    send_pair(0, 0, 0, 0, 0, 0, 0);
    send_pair(32767, 32767, 32767, -32768, -32768, 0, 0);
    send_pair(-32768, -32768, 32767, 32767, 32767, 0, 0);
    send_pair(-32768, 32767, 32767, 32767, -32768, 32767, 32767);
    send_pair(100, 0, 50, 0, 0, 20, 20);
    send_pair(-100, 0, 200, 0, 0, 20, 20);
    send_pair(0, 100, 200, 0, 0, 20, 20);
    send_pair(0, -100, 200, 0, 0, 20, 20);
    send_pair(100, 100, 300, 0, 0, 20, 20);
    send_pair(100, 0, 45, 0, 0, 110, 0);
    send_pair(100, 0, 46, 0, 0, 110, 0);
    send_pair(32767, 0, 32767, -32768, 0, 32767, 0);
    send_pair(-5, 7, 32767, 0, 0, 0, 0);
    send_pair(1, 1, 1, 0, 0, 0, 0);
  endtask

  task automatic test_random_near();
    logic signed [15:0] bx, by;
    logic [14:0] w, h;
    for (int i = 0; i < 900; i++) begin
      bx = 16'($urandom);
      by = 16'($urandom);
      w = ($urandom_range(0, 9) == 0) ? 15'($urandom) : 15'($urandom_range(0, 2000));
      h = ($urandom_range(0, 9) == 0) ? 15'($urandom) : 15'($urandom_range(0, 2000));
      send_pair(16'(bx + $signed(12'($urandom))), 16'(by + $signed(12'($urandom))),
                ($urandom_range(0, 7) == 0) ? 15'($urandom) : 15'($urandom_range(0, 3000)),
                bx, by, w, h, i % 200 > 20);
    end
  endtask

  task automatic test_random_full();
    rsp_stall_on = 0;
    for (int i = 0; i < 250; i++)
      send_pair(16'($urandom), 16'($urandom), 15'($urandom), 16'($urandom), 16'($urandom),
                15'($urandom), 15'($urandom), i > 60);
    rsp_stall_on = 1;
  endtask

  initial begin
    rst = 1;
    req.valid = 0;
    req.circle_x = 0;
    req.circle_y = 0;
    req.circle_radius = 0;
    req.box_x = 0;
    req.box_y = 0;
    req.box_width = 0;
    req.box_height = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 0;
    test_extremes();
    test_random_near();
    test_random_full();
    @(negedge clk);
    req.valid <= 0;
    while (expected_contacts.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("checked %0d contact results, %0d of them hits", contacts_seen, hits_seen);
    if (errors == 0) $display("circle_box_collision_unit regression: pass");
    else $display("circle_box_collision_unit regression: fail");
    $finish;
  end
endmodule

// File: files.f
hw/rtl/cbc_pkg.sv
hw/rtl/cbc_req_if.sv
hw/rtl/cbc_rsp_if.sv
hw/rtl/cbc_front.sv
hw/rtl/cbc_queue.sv
hw/rtl/cbc_back.sv
hw/rtl/circle_box_collision_unit.sv
tb/circle_box_collision_unit_tb.sv
